/* design/rsfl_pkg.sv */
// Shared types and constants for the record slot free-list allocator.
`default_nettype none
package rsfl_pkg;

  localparam int PAGE_W  = 8;
  localparam int SLOT_W  = 6;
  localparam int SLOT_AW = PAGE_W + SLOT_W;
  localparam int LEN_W   = 13;
  localparam int SPP_W   = 7;

  localparam logic [PAGE_W-1:0] PAGE_LIMIT  = 8'd255;
  localparam logic [PAGE_W-1:0] PAGE_NONE   = '0;
  localparam logic [LEN_W-1:0]  OFFSET_BASE = 13'd4;
  localparam logic [SPP_W-1:0]  SLOT_CAP    = 7'd64;

  localparam logic [LEN_W-1:0]  RECORD_LEN_RST = 13'd64;
  localparam logic [SPP_W-1:0]  SLOTS_RST      = 7'd64;

  localparam logic CFG_RECORD_LEN = 1'b0;
  localparam logic CFG_SLOTS      = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PAGE = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC_REC  = 2'd0,
    CMD_FREE_REC   = 2'd1,
    CMD_ALLOC_PAGE = 2'd2,
    CMD_FREE_PAGE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
  } slot_link_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    slot_link_t         wdata;
  } slot_req_t;

  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] addr;
    logic [PAGE_W-1:0] wdata;
  } page_req_t;

endpackage
`default_nettype wire

/* design/record_slot_free_list_allocator_top.sv */
// Top level of the record slot free-list allocator: config registers and link stores.
//
// Command-style allocator for fixed-size record slots kept in pages. A request
// is taken on a clock edge with start high and busy low; its single result
// appears in the cycle after the request completes, on the out_ ports for exactly
// one cycle with out_valid high. The receiver cannot stall, so it must take
// every result in that cycle. Steps per request, set by the sequencer
// stepping through one link-memory access per cycle:
//   free record / free page, and allocations that run out of pages: none
//   allocate record with a non-empty slot list: link read
//   allocate page reusing a freed page: page read, page push
//   allocate page with a fresh page: format, page push
//   allocate record needing a page: [page read if reused,] format, push, link read
// where format writes one slot link per cycle, one for each of slots_per_page
// slots clamped to 1..64. busy drops in the cycle the result is shown,
// so the next request may start then. Both link stores are synchronous
// single-port RAMs with no reset; they need no clearing pass because entries
// are only read after being written. Config writes are taken any cycle but
// must only be issued while the block is idle.
`default_nettype none
module record_slot_free_list_allocator_top
  import rsfl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_command,
  input  wire logic [PAGE_W-1:0] in_page_number,
  input  wire logic [SLOT_W-1:0] in_record_slot,
  output logic                   out_valid,
  output logic                   out_status,
  output logic      [PAGE_W-1:0] out_result_page,
  output logic      [SLOT_W-1:0] out_result_slot,
  output logic      [LEN_W-1:0]  out_result_offset,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [LEN_W-1:0]  cfg_wdata
);

  logic [LEN_W-1:0]  record_len_r, record_len_nxt;
  logic [SPP_W-1:0]  slots_r, slots_nxt;
  logic [SLOT_W-1:0] last_slot;

  slot_req_t         slot_req;
  slot_link_t        slot_rdata;
  page_req_t         page_req;
  logic [PAGE_W-1:0] page_rdata;

  // config register file
  always_comb begin
    record_len_nxt = record_len_r;
    slots_nxt      = slots_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RECORD_LEN: record_len_nxt = cfg_wdata;
        CFG_SLOTS:      slots_nxt      = cfg_wdata[SPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_len_r <= RECORD_LEN_RST;
      slots_r      <= SLOTS_RST;
    end else begin
      record_len_r <= record_len_nxt;
      slots_r      <= slots_nxt;
    end
  end

  // index of the last slot formatted into a page; count clamped to 1..64
  always_comb begin
    if (slots_r == '0) begin
      last_slot = '0;
    end else if (slots_r >= SLOT_CAP) begin
      last_slot = '1;
    end else begin
      last_slot = SLOT_W'(slots_r - 1'b1);
    end
  end

  rsfl_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_command        (in_command),
    .in_page_number    (in_page_number),
    .in_record_slot    (in_record_slot),
    .record_len        (record_len_r),
    .last_slot         (last_slot),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_page   (out_result_page),
    .out_result_slot   (out_result_slot),
    .out_result_offset (out_result_offset),
    .slot_req          (slot_req),
    .slot_rdata        (slot_rdata),
    .page_req          (page_req),
    .page_rdata        (page_rdata)
  );

  // one link word per slot, addressed by {page, slot}
  rsfl_ram #(
    .ADDR_W (SLOT_AW),
    .DATA_W ($bits(slot_link_t))
  ) u_slot_links (
    .clk   (clk),
    .we    (slot_req.we),
    .addr  (slot_req.addr),
    .wdata (slot_req.wdata),
    .rdata (slot_rdata)
  );

  // one link word per page, shared by the free and in-use page lists
  rsfl_ram #(
    .ADDR_W (PAGE_W),
    .DATA_W (PAGE_W)
  ) u_page_links (
    .clk   (clk),
    .we    (page_req.we),
    .addr  (page_req.addr),
    .wdata (page_req.wdata),
    .rdata (page_rdata)
  );

endmodule
`default_nettype wire

/* design/rsfl_ram.sv */
// Generic single-port synchronous RAM, read-first, registered read data.
`default_nettype none
module rsfl_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* design/rsfl_ctrl.sv */
// Command sequencer: list heads, page counter, page formatting and results.
`default_nettype none
module rsfl_ctrl
  import rsfl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_command,
  input  wire logic [PAGE_W-1:0] in_page_number,
  input  wire logic [SLOT_W-1:0] in_record_slot,
  input  wire logic [LEN_W-1:0]  record_len,
  input  wire logic [SLOT_W-1:0] last_slot,
  output logic                   busy,
  output logic                   out_valid,
  output logic                   out_status,
  output logic      [PAGE_W-1:0] out_result_page,
  output logic      [SLOT_W-1:0] out_result_slot,
  output logic      [LEN_W-1:0]  out_result_offset,
  output slot_req_t              slot_req,
  input  wire slot_link_t        slot_rdata,
  output page_req_t              page_req,
  input  wire logic [PAGE_W-1:0] page_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAGE_RD,
    S_FORMAT,
    S_PAGE_PUSH,
    S_SLOT_RD
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  slot_link_t        head_r, head_nxt;
  logic [PAGE_W-1:0] free_head_r, free_head_nxt;
  logic [PAGE_W-1:0] used_head_r, used_head_nxt;
  logic [PAGE_W-1:0] highest_r, highest_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  logic              valid_r, valid_nxt;
  logic              status_r, status_nxt;
  logic [PAGE_W-1:0] rpage_r, rpage_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [LEN_W-1:0]  roff_r, roff_nxt;

  logic [SLOT_W+LEN_W-1:0] prod;

  // byte offset of the slot at the list head, before OFFSET_BASE is added
  assign prod = {{LEN_W{1'b0}}, head_r.slot} * {{SLOT_W{1'b0}}, record_len};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    free_head_nxt = free_head_r;
    used_head_nxt = used_head_r;
    highest_nxt   = highest_r;
    page_nxt      = page_r;
    idx_nxt       = idx_r;
    valid_nxt     = 1'b0;
    status_nxt    = STATUS_OK;
    rpage_nxt     = '0;
    rslot_nxt     = '0;
    roff_nxt      = '0;
    slot_req      = '0;
    page_req      = '0;
    slot_req.addr = {head_r.page, head_r.slot};
    page_req.addr = free_head_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_command);
          case (cmd_t'(in_command))
            CMD_ALLOC_REC, CMD_ALLOC_PAGE: begin
              if ((cmd_t'(in_command) == CMD_ALLOC_REC) && head_r.valid) begin
                state_nxt = S_SLOT_RD;
              end else if (free_head_r != PAGE_NONE) begin
                state_nxt = S_PAGE_RD;
              end else if (highest_r >= PAGE_LIMIT) begin
                valid_nxt  = 1'b1;
                status_nxt = STATUS_NO_PAGE;
              end else begin
                highest_nxt = highest_r + 1'b1;
                page_nxt    = highest_r + 1'b1;
                idx_nxt     = '0;
                state_nxt   = S_FORMAT;
              end
            end
            CMD_FREE_REC: begin
              slot_req.we    = 1'b1;
              slot_req.addr  = {in_page_number, in_record_slot};
              slot_req.wdata = head_r;
              head_nxt       = '{valid: 1'b1, page: in_page_number, slot: in_record_slot};
              valid_nxt      = 1'b1;
            end
            CMD_FREE_PAGE: begin
              if (in_page_number != PAGE_NONE) begin
                page_req.we    = 1'b1;
                page_req.addr  = in_page_number;
                page_req.wdata = free_head_r;
                free_head_nxt  = in_page_number;
              end
              valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_PAGE_RD: begin
        page_nxt      = free_head_r;
        free_head_nxt = page_rdata;
        idx_nxt       = '0;
        // reused pages are formatted only for record allocation
        state_nxt     = (cmd_r == CMD_ALLOC_REC) ? S_FORMAT : S_PAGE_PUSH;
      end
      S_FORMAT: begin
        slot_req.we   = 1'b1;
        slot_req.addr = {page_r, idx_r};
        if (idx_r == last_slot) begin
          slot_req.wdata = head_r;
          head_nxt       = '{valid: 1'b1, page: page_r, slot: '0};
          state_nxt      = S_PAGE_PUSH;
        end else begin
          slot_req.wdata = '{valid: 1'b1, page: page_r, slot: idx_r + 1'b1};
          idx_nxt        = idx_r + 1'b1;
        end
      end
      S_PAGE_PUSH: begin
        page_req.we    = 1'b1;
        page_req.addr  = page_r;
        page_req.wdata = used_head_r;
        used_head_nxt  = page_r;
        if (cmd_r == CMD_ALLOC_REC) begin
          state_nxt = S_SLOT_RD;
        end else begin
          valid_nxt = 1'b1;
          rpage_nxt = page_r;
          state_nxt = S_IDLE;
        end
      end
      S_SLOT_RD: begin
        valid_nxt = 1'b1;
        rpage_nxt = head_r.page;
        rslot_nxt = head_r.slot;
        roff_nxt  = prod[LEN_W-1:0] + OFFSET_BASE;
        head_nxt  = slot_rdata;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_ALLOC_REC;
      head_r      <= '0;
      free_head_r <= PAGE_NONE;
      used_head_r <= PAGE_NONE;
      highest_r   <= '0;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      head_r      <= head_nxt;
      free_head_r <= free_head_nxt;
      used_head_r <= used_head_nxt;
      highest_r   <= highest_nxt;
      valid_r     <= valid_nxt;
    end
    page_r   <= page_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    rpage_r  <= rpage_nxt;
    rslot_r  <= rslot_nxt;
    roff_r   <= roff_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_result_page   = rpage_r;
  assign out_result_slot   = rslot_r;
  assign out_result_offset = roff_r;

endmodule
`default_nettype wire

/* dv/record_slot_free_list_allocator_top_tb.sv */
// Self-checking testbench for the record slot free-list allocator top level.
`timescale 1ns / 1ps
module record_slot_free_list_allocator_top_tb;
  import rsfl_pkg::*;

  // One result per request: status plus the allocated page, slot and byte offset.
  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  offset;
  } alloc_result_t;

  // Shadow allocator: its own copy of the registers, list heads and link stores.
  // note_request() predicts the result of an accepted request and queues it;
  // check_result() compares each strobed result with the oldest prediction.
  class allocation_scoreboard;
    logic [LEN_W-1:0]  record_len;
    logic [SPP_W-1:0]  slots_per_page;
    logic              head_valid;
    logic [PAGE_W-1:0] head_page;
    logic [SLOT_W-1:0] head_slot;
    logic [PAGE_W-1:0] free_page_head;
    logic [PAGE_W-1:0] highest_page;
    logic [PAGE_W-1:0] used_page_head;
    slot_link_t        slot_links [0:(1 << SLOT_AW) - 1];
    logic [PAGE_W-1:0] page_links [0:(1 << PAGE_W) - 1];
    alloc_result_t     pending_results [$];
    int                error_count;

    function new();
      record_len     = RECORD_LEN_RST;
      slots_per_page = SLOTS_RST;
      head_valid     = 1'b0;
      head_page      = PAGE_NONE;
      head_slot      = '0;
      free_page_head = PAGE_NONE;
      highest_page   = PAGE_NONE;
      used_page_head = PAGE_NONE;
      error_count    = 0;
    endfunction

    function void write_register(logic idx, logic [LEN_W-1:0] value);
      if (idx == CFG_RECORD_LEN) begin
        record_len = value;
      end else begin
        slots_per_page = value[SPP_W-1:0];
      end
    endfunction

    // Thread slots 0..n-1 in order onto the front of the free-slot list.
    function void format_page(logic [PAGE_W-1:0] pg);
      int n;
      n = int'(slots_per_page);
      if (n < 1) n = 1;
      if (n > SLOT_CAP) n = int'(SLOT_CAP);
      for (int i = 0; i < n - 1; i++)
        slot_links[{pg, SLOT_W'(i)}] = slot_link_t'{1'b1, pg, SLOT_W'(i + 1)};
      slot_links[{pg, SLOT_W'(n - 1)}] = slot_link_t'{head_valid, head_page, head_slot};
      head_valid = 1'b1;
      head_page  = pg;
      head_slot  = '0;
    endfunction

    // Freed page first, else a fresh one from the counter; PAGE_NONE when out.
    function logic [PAGE_W-1:0] take_page(bit format_reused);
      logic [PAGE_W-1:0] pg;
      if (free_page_head != PAGE_NONE) begin
        pg = free_page_head;
        free_page_head = page_links[pg];
        if (format_reused) format_page(pg);
      end else begin
        if (highest_page >= PAGE_LIMIT) return PAGE_NONE;
        highest_page = highest_page + 1'b1;
        pg = highest_page;
        format_page(pg);
      end
      page_links[pg] = used_page_head;
      used_page_head = pg;
      return pg;
    endfunction

    function alloc_result_t note_request(cmd_t c, logic [PAGE_W-1:0] pg,
                                         logic [SLOT_W-1:0] sl);
      alloc_result_t r;
      slot_link_t    nxt;
      bit            have_slot;
      r = '0;
      case (c)
        CMD_ALLOC_REC: begin
          have_slot = head_valid;
          if (!have_slot) have_slot = (take_page(1'b1) != PAGE_NONE);
          if (!have_slot) begin
            r.status = STATUS_NO_PAGE;
          end else begin
            nxt      = slot_links[{head_page, head_slot}];
            r.page   = head_page;
            r.slot   = head_slot;
            r.offset = OFFSET_BASE + head_slot * record_len;  // wraps at 13 bits
            head_valid = nxt.valid;
            head_page  = nxt.page;
            head_slot  = nxt.slot;
          end
        end
        CMD_FREE_REC: begin
          slot_links[{pg, sl}] = slot_link_t'{head_valid, head_page, head_slot};
          head_valid = 1'b1;
          head_page  = pg;
          head_slot  = sl;
        end
        CMD_ALLOC_PAGE: begin
          r.page = take_page(1'b0);
          if (r.page == PAGE_NONE) r.status = STATUS_NO_PAGE;
        end
        default: begin
          // page zero is the list terminator, so freeing it does nothing
          if (pg != PAGE_NONE) begin
            page_links[pg] = free_page_head;
            free_page_head = pg;
          end
        end
      endcase
      pending_results.push_back(r);
      return r;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("result_page", want.page, got.page);
      compare_field("result_slot", want.slot, got.slot);
      compare_field("result_offset", want.offset, got.offset);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_command = CMD_ALLOC_REC;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic [SLOT_W-1:0] in_record_slot = '0;
  logic              out_valid;
  logic              out_status;
  logic [PAGE_W-1:0] out_result_page;
  logic [SLOT_W-1:0] out_result_slot;
  logic [LEN_W-1:0]  out_result_offset;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_RECORD_LEN;
  logic [LEN_W-1:0]  cfg_wdata = '0;

  allocation_scoreboard board = new();

  // Records and pages handed out so far; frees mostly draw from these so that
  // the lists see well-formed traffic, the rest are arbitrary page/slot pairs.
  logic [SLOT_AW-1:0] live_records [$];
  logic [PAGE_W-1:0]  live_pages [$];
  int                 no_page_results = 0;

  record_slot_free_list_allocator_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_page_number    (in_page_number),
    .in_record_slot    (in_record_slot),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_page   (out_result_page),
    .out_result_slot   (out_result_slot),
    .out_result_offset (out_result_offset),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Results cannot be stalled: every strobed cycle is checked at its closing edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result(alloc_result_t'{out_status, out_result_page,
                                         out_result_slot, out_result_offset});
    end
  end

  // Hold the request until start && !busy is seen at an edge, then predict it.
  // start stays high so back-to-back requests go in without a bubble.
  task automatic issue_request(input cmd_t c, input logic [PAGE_W-1:0] pg,
                               input logic [SLOT_W-1:0] sl);
    alloc_result_t r;
    start          <= 1'b1;
    in_command     <= c;
    in_page_number <= pg;
    in_record_slot <= sl;
    do @(posedge clk); while (busy);
    r = board.note_request(c, pg, sl);
    if (r.status == STATUS_NO_PAGE) begin
      no_page_results++;
    end else if (c == CMD_ALLOC_REC) begin
      live_records.push_back({r.page, r.slot});
    end else if (c == CMD_ALLOC_PAGE) begin
      live_pages.push_back(r.page);
    end
  endtask

  // Sender bubbles: each cycle idles with the given percentage.
  task automatic sender_idle(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    while (board.pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block idle; the enable drops before the next write.
  task automatic write_register(input logic idx, input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_register(idx, value);
    @(posedge clk);
  endtask

  // Weighted command mix; free-page weight is what is left of 100.
  // Freeing page zero is ignored by the block and not counted.
  task automatic random_phase(input int n_items, input int idle_pct, input int w_arec,
                              input int w_frec, input int w_apage,
                              input bit stop_when_full);
    int                done;
    int                r;
    int                k;
    cmd_t              c;
    logic [PAGE_W-1:0] pg;
    logic [SLOT_W-1:0] sl;
    done = 0;
    while (done < n_items && !(stop_when_full && no_page_results >= 25)) begin
      sender_idle(idle_pct);
      if ($urandom_range(99) < 3) drain();
      r  = $urandom_range(99);
      pg = PAGE_W'($urandom_range(255));
      sl = SLOT_W'($urandom_range(63));
      if (r < w_arec) begin
        c = CMD_ALLOC_REC;
      end else if (r < w_arec + w_frec) begin
        c = CMD_FREE_REC;
        if (live_records.size() != 0 && $urandom_range(3) != 0) begin
          k = $urandom_range(live_records.size() - 1);
          {pg, sl} = live_records[k];
          live_records.delete(k);
        end
      end else if (r < w_arec + w_frec + w_apage) begin
        c = CMD_ALLOC_PAGE;
      end else begin
        c = CMD_FREE_PAGE;
        if (live_pages.size() != 0 && $urandom_range(3) != 0) begin
          k = $urandom_range(live_pages.size() - 1);
          pg = live_pages[k];
          live_pages.delete(k);
        end
      end
      issue_request(c, pg, sl);
      if (!(c == CMD_FREE_PAGE && pg == PAGE_NONE)) done++;
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, one-slot pages (zero clamps up to one), widest stride.
    write_register(CFG_RECORD_LEN, 13'd8188);
    write_register(CFG_SLOTS, 13'd0);
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);   // empty list, fresh page 1
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);   // fresh page 2
    issue_request(CMD_FREE_PAGE, 8'd1, 6'd0);
    issue_request(CMD_FREE_PAGE, PAGE_NONE, 6'd0);   // page zero: no effect
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);   // reused page 1 gets formatted
    issue_request(CMD_FREE_REC, 8'd2, 6'd0);
    issue_request(CMD_FREE_REC, 8'd255, 6'd63);      // unchecked free, top page/slot
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);   // slot 63: offset wraps
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    issue_request(CMD_ALLOC_PAGE, PAGE_NONE, 6'd0);  // fresh page, formatted
    issue_request(CMD_FREE_PAGE, 8'd3, 6'd0);
    issue_request(CMD_ALLOC_PAGE, PAGE_NONE, 6'd0);  // reused page, not formatted
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    issue_request(CMD_FREE_PAGE, 8'd255, 6'd0);
    issue_request(CMD_ALLOC_PAGE, PAGE_NONE, 6'd0);
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    drain();

    // Directed, slot count above range clamps to 64, narrowest stride.
    write_register(CFG_RECORD_LEN, 13'd6);
    write_register(CFG_SLOTS, 13'd127);
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    issue_request(CMD_FREE_REC, PAGE_NONE, 6'd0);    // page zero slot zero is legal
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    issue_request(CMD_ALLOC_REC, PAGE_NONE, 6'd0);
    issue_request(CMD_FREE_REC, 8'd170, 6'd42);
    issue_request(CMD_FREE_REC, 8'd85, 6'd21);
    drain();

    // Random, reset register values, light sender bubbles.
    write_register(CFG_RECORD_LEN, RECORD_LEN_RST);
    write_register(CFG_SLOTS, 13'(SLOTS_RST));
    random_phase(70, 12, 40, 30, 15, 1'b0);

    // Random settings, heavy sender bubbles.
    write_register(CFG_RECORD_LEN, 13'($urandom_range(6, 8188)));
    write_register(CFG_SLOTS, 13'($urandom_range(2, 64)));
    random_phase(70, 70, 35, 25, 25, 1'b0);

    // Back to back, one slot per page, page-heavy mix: drives the counter to its
    // limit so both allocations report out of pages.
    write_register(CFG_RECORD_LEN, 13'($urandom_range(6, 8188)));
    write_register(CFG_SLOTS, 13'd1);
    random_phase(400, 0, 22, 5, 70, 1'b1);

    // drain() already waited for every result; cover the longest request too.
    repeat (70) @(posedge clk);
    if (board.error_count == 0 && board.pending_results.size() == 0) begin
      $display("record_slot_free_list_allocator_top verification clean");
    end else begin
      $display("record_slot_free_list_allocator_top verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("record_slot_free_list_allocator_top verification failed");
    $finish;
  end

endmodule
